// File: design/aes_pkg.sv
// Package for the AES-128 block cipher: S-box functions, GF(2^8) helpers,
// round-function helpers on a 128-bit column-major state. No dependencies.
`default_nettype none
package aes_pkg;

  localparam int unsigned RoundCountDef = 10;

  typedef enum logic [0:0] {
    OP_ENC = 1'b0,
    OP_DEC = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    REG_KEY_HIGH = 1'b0,
    REG_KEY_LOW  = 1'b1
  } reg_idx_e;

  localparam logic [0:255][7:0] FwdSbox = {
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
    8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
    8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
    8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
    8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
    8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
    8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
    8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
    8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
    8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
    8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
    8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
    8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
    8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
    8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
    8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
    8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [0:255][7:0] InvSbox = {
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,
    8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,
    8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,
    8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,
    8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,
    8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,
    8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,
    8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,
    8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,
    8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,
    8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
    8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,
    8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,
    8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,
    8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,
    8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,
    8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // state byte n sits at bits [127-8n -: 8]
  function automatic logic [7:0] sb(input logic [127:0] s, input int n);
    return s[127-8*n -: 8];
  endfunction

  function automatic logic [31:0] sbox_word(input logic [31:0] w);
    return {FwdSbox[w[31:24]], FwdSbox[w[23:16]], FwdSbox[w[15:8]], FwdSbox[w[7:0]]};
  endfunction

  function automatic logic [127:0] fwd_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = FwdSbox[sb(s, 4*((c+r)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] inv_sub_shift(input logic [127:0] s);
    logic [127:0] t;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127-8*(4*c+r) -: 8] = InvSbox[sb(s, 4*((c+3*r)%4)+r)];
      end
    end
    return t;
  endfunction

  function automatic logic [127:0] fwd_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      a0 = sb(s, 4*c); a1 = sb(s, 4*c+1); a2 = sb(s, 4*c+2); a3 = sb(s, 4*c+3);
      t[127-8*(4*c)   -: 8] = xt(a0) ^ xt(a1) ^ a1 ^ a2 ^ a3;
      t[127-8*(4*c+1) -: 8] = a0 ^ xt(a1) ^ xt(a2) ^ a2 ^ a3;
      t[127-8*(4*c+2) -: 8] = a0 ^ a1 ^ xt(a2) ^ xt(a3) ^ a3;
      t[127-8*(4*c+3) -: 8] = xt(a0) ^ a0 ^ a1 ^ a2 ^ xt(a3);
    end
    return t;
  endfunction

  // inverse mix = forward mix after the pre-step u = x^2(a0^a2), v = x^2(a1^a3)
  function automatic logic [127:0] inv_mix(input logic [127:0] s);
    logic [127:0] t;
    logic [7:0] u, v;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      u = xt(xt(sb(s, 4*c) ^ sb(s, 4*c+2)));
      v = xt(xt(sb(s, 4*c+1) ^ sb(s, 4*c+3)));
      t[127-8*(4*c)   -: 8] = sb(s, 4*c) ^ u;
      t[127-8*(4*c+1) -: 8] = sb(s, 4*c+1) ^ v;
      t[127-8*(4*c+2) -: 8] = sb(s, 4*c+2) ^ u;
      t[127-8*(4*c+3) -: 8] = sb(s, 4*c+3) ^ v;
    end
    return fwd_mix(t);
  endfunction

endpackage
`default_nettype wire

// File: design/aes128_block_cipher.sv
// AES-128 top level: key registers, key schedule kept in a round-key memory,
// and one shared round unit under a small sequencer. Uses aes_pkg.
//
// Usage: write key_high (index 0) and key_low (index 1) through cfg_we_i /
// cfg_idx_i / cfg_data_i while the block is idle. Pulse start_i with the
// operation and the block; the item is taken when busy_o is low. After the
// result beat, done_o is high for one cycle with result_high_o/result_low_o.
// The receiver cannot stall; the result must be taken in that cycle.
// Sequence: a load step adds the initial round key, then the shared round
// unit runs the ten rounds, one round per cycle, and done_o is high in the cycle
// after the last round. The first item after a key write first expands the
// key, one round key (four words) per cycle, before the load step. busy_o
// falls at the edge that ends the result beat, and only then can a new item
// be taken; one item at a time.
// Reset clears the key registers to zero and marks the schedule stale, so
// the all-zero key is expanded on the first item.
`default_nettype none
module aes128_block_cipher
  import aes_pkg::*;
#(
  parameter int unsigned RoundCount = RoundCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [63:0] cfg_data_i,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic        operation_i,
  input  wire logic [63:0] block_high_i,
  input  wire logic [63:0] block_low_i,
  output logic             done_o,
  output logic [63:0]      result_high_o,
  output logic [63:0]      result_low_o
);

  localparam int unsigned RkW = $clog2(RoundCount + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXP   = 5'b00010,
    ST_LOAD  = 5'b00100,
    ST_ROUND = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e         state_q, state_d;
  logic [63:0]    key_hi_q, key_lo_q;
  logic           ready_q;
  logic [127:0]   rk_mem [RoundCount+1];
  logic [127:0]   rk_rd_q;
  logic [127:0]   exp_q;
  logic [7:0]     rcon_q;
  logic [RkW-1:0] cnt_q;
  logic [127:0]   st_q;
  logic [127:0]   din_q;
  logic           op_q;

  logic [127:0]   exp_next;
  logic [RkW-1:0] rd_addr;
  logic [127:0]   round_out;
  logic           last_rnd;
  logic [31:0]    tw;

  assign busy_o = (state_q != ST_IDLE);
  assign last_rnd = (cnt_q == RkW'(RoundCount));

  always_comb begin
    tw = sbox_word({exp_q[23:0], exp_q[31:24]}) ^ {rcon_q, 24'h0};
    exp_next[127:96] = exp_q[127:96] ^ tw;
    exp_next[95:64]  = exp_q[95:64] ^ exp_next[127:96];
    exp_next[63:32]  = exp_q[63:32] ^ exp_next[95:64];
    exp_next[31:0]   = exp_q[31:0] ^ exp_next[63:32];
  end

  // round key address for the round after the current one
  always_comb begin
    if (state_q == ST_LOAD) begin
      rd_addr = op_q ? RkW'(RoundCount - 1) : RkW'(1);
    end else if (op_q) begin
      rd_addr = RkW'(RoundCount - 1) - cnt_q;
    end else begin
      rd_addr = cnt_q + RkW'(1);
    end
  end

  always_comb begin
    if (op_q == OP_DEC) begin
      round_out = inv_sub_shift(st_q) ^ rk_rd_q;
      if (!last_rnd) round_out = inv_mix(round_out);
    end else begin
      round_out = fwd_sub_shift(st_q);
      if (!last_rnd) round_out = fwd_mix(round_out);
      round_out = round_out ^ rk_rd_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (start_i) state_d = ready_q ? ST_LOAD : ST_EXP;
      ST_EXP:   if (cnt_q == RkW'(RoundCount)) state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_ROUND;
      ST_ROUND: if (last_rnd) state_d = ST_DONE;
      ST_DONE:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      key_hi_q <= '0;
      key_lo_q <= '0;
      ready_q  <= 1'b0;
      cnt_q    <= '0;
      done_o   <= 1'b0;
    end else begin
      state_q <= state_d;
      done_o  <= (state_q == ST_ROUND) && last_rnd;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_KEY_HIGH) key_hi_q <= cfg_data_i;
        else key_lo_q <= cfg_data_i;
      end
      if (cfg_we_i) begin
        ready_q <= 1'b0;
      end else if (state_q == ST_EXP && cnt_q == RkW'(RoundCount)) begin
        ready_q <= 1'b1;
      end
      case (state_q)
        ST_IDLE:  cnt_q <= '0;
        ST_EXP: begin
          if (cnt_q == RkW'(RoundCount)) cnt_q <= '0;
          else cnt_q <= cnt_q + RkW'(1);
        end
        ST_LOAD:  cnt_q <= RkW'(1);
        ST_ROUND: cnt_q <= cnt_q + RkW'(1);
        ST_DONE:  cnt_q <= '0;
        default:  cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_q   <= operation_i;
      din_q  <= {block_high_i, block_low_i};
      exp_q  <= {key_hi_q, key_lo_q};
      rcon_q <= 8'h01;
    end
    if (state_q == ST_EXP) begin
      rk_mem[cnt_q] <= exp_q;
      exp_q  <= exp_next;
      rcon_q <= xt(rcon_q);
    end
    if (state_q == ST_IDLE) begin
      rk_rd_q <= rk_mem[(operation_i == OP_DEC) ? RkW'(RoundCount) : RkW'(0)];
    end else if (state_q == ST_EXP) begin
      // last round key is still being written on the final expansion cycle
      rk_rd_q <= (op_q == OP_DEC) ? exp_q : rk_mem[RkW'(0)];
    end else begin
      rk_rd_q <= rk_mem[rd_addr];
    end
    if (state_q == ST_LOAD) begin
      st_q <= din_q ^ rk_rd_q;
    end else if (state_q == ST_ROUND) begin
      st_q <= round_out;
      if (last_rnd) begin
        result_high_o <= round_out[127:64];
        result_low_o  <= round_out[63:0];
      end
    end
  end

endmodule
`default_nettype wire

// File: dv/tb_aes128_block_cipher.sv
// Testbench for aes128_block_cipher: drives key writes and cipher blocks,
// predicts each output block with its own AES-128 model. Depends on aes_pkg.
`timescale 1ns / 1ps
module tb_aes128_block_cipher;
  import aes_pkg::*;

  typedef struct packed {
    logic [63:0] hi;
    logic [63:0] lo;
  } blk_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [63:0] cfg_data_i = '0;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic        operation_i = 1'b0;
  logic [63:0] block_high_i = '0;
  logic [63:0] block_low_i = '0;
  logic        done_o;
  logic [63:0] result_high_o;
  logic [63:0] result_low_o;

  aes128_block_cipher uut (.*);

  always #4 clk_i = ~clk_i;

  logic [7:0]  sbox_fwd [256];
  logic [7:0]  sbox_inv [256];
  logic [63:0] key_hi_q, key_lo_q;
  logic [31:0] sched [44];
  bit          sched_ok;
  blk_t        expected_blocks [$];
  int          fail_cnt;
  int          idle_pct;

  function automatic logic [7:0] gdbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    acc = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc ^= a;
      a = gdbl(a);
    end
    return acc;
  endfunction

  // build the forward and inverse S-boxes from the field inverse and affine map
  task automatic build_sboxes();
    logic [7:0] inv, x, y;
    for (int v = 0; v < 256; v++) begin
      inv = '0;
      for (int w = 1; w < 256; w++) if (gmul(8'(v), 8'(w)) == 8'h01) inv = 8'(w);
      x = inv;
      y = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]}
          ^ 8'h63;
      sbox_fwd[v] = y;
      sbox_inv[y] = 8'(v);
    end
  endtask

  function automatic void build_schedule();
    logic [31:0] t;
    logic [7:0]  rc;
    rc = 8'h01;
    sched[0] = key_hi_q[63:32]; sched[1] = key_hi_q[31:0];
    sched[2] = key_lo_q[63:32]; sched[3] = key_lo_q[31:0];
    for (int i = 4; i < 44; i++) begin
      t = sched[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sbox_fwd[t[31:24]], sbox_fwd[t[23:16]], sbox_fwd[t[15:8]], sbox_fwd[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = gdbl(rc);
      end
      sched[i] = sched[i-4] ^ t;
    end
    sched_ok = 1'b1;
  endfunction

  function automatic blk_t cipher_block(input op_e op, input logic [63:0] hi,
                                        input logic [63:0] lo);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] fc [4];
    logic [7:0] ic [4];
    logic [7:0] col [4];
    logic [7:0] v;
    int rnd, rot;
    blk_t o;
    fc = '{8'd2, 8'd3, 8'd1, 8'd1};
    ic = '{8'd14, 8'd11, 8'd13, 8'd9};
    if (!sched_ok) build_schedule();
    for (int i = 0; i < 8; i++) begin
      s[i] = hi[63-8*i -: 8];
      s[8+i] = lo[63-8*i -: 8];
    end
    for (int step = 0; step <= 10; step++) begin
      rnd = (op == OP_ENC) ? step : 10 - step;
      if (step != 0) begin
        rot = (op == OP_ENC) ? 1 : 3;
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c + r*rot) % 4) + r];
        for (int i = 0; i < 16; i++) s[i] = (op == OP_ENC) ? sbox_fwd[t[i]] : sbox_inv[t[i]];
      end
      // encrypt: mix before key add; decrypt: after
      if (op == OP_ENC && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
          for (int r = 0; r < 4; r++) begin
            v = '0;
            for (int k = 0; k < 4; k++) v ^= gmul(col[k], fc[(k - r + 4) % 4]);
            s[4*c+r] = v;
          end
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) s[4*c+r] ^= sched[rnd*4+c][31-8*r -: 8];
      if (op == OP_DEC && step != 0 && step != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int k = 0; k < 4; k++) col[k] = s[4*c+k];
          for (int r = 0; r < 4; r++) begin
            v = '0;
            for (int k = 0; k < 4; k++) v ^= gmul(col[k], ic[(k - r + 4) % 4]);
            s[4*c+r] = v;
          end
        end
      end
    end
    for (int i = 0; i < 8; i++) begin
      o.hi[63-8*i -: 8] = s[i];
      o.lo[63-8*i -: 8] = s[8+i];
    end
    return o;
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_block(input op_e op, input logic [63:0] hi, input logic [63:0] lo);
    idle_gap();
    start_i <= 1'b1;
    operation_i <= op;
    block_high_i <= hi;
    block_low_i <= lo;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    expected_blocks.push_back(cipher_block(op, hi, lo));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (expected_blocks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_key(input reg_idx_e idx, input logic [63:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_KEY_HIGH) key_hi_q = val;
    else key_lo_q = val;
    sched_ok = 1'b0;
  endtask

  always @(posedge clk_i) begin
    blk_t e;
    if (rst_ni && done_o) begin
      if (expected_blocks.size() == 0) begin
        $error("unexpected result %h %h", result_high_o, result_low_o);
        fail_cnt++;
      end else begin
        e = expected_blocks.pop_front();
        if (result_high_o !== e.hi) begin
          $error("result_high expected %h actual %h", e.hi, result_high_o);
          fail_cnt++;
        end
        if (result_low_o !== e.lo) begin
          $error("result_low expected %h actual %h", e.lo, result_low_o);
          fail_cnt++;
        end
      end
    end
  end

  task automatic test_zero_key();
    send_block(OP_ENC, '0, '0);
    send_block(OP_DEC, '0, '0);
    send_block(OP_ENC, '1, '1);
    send_block(OP_DEC, '1, '1);
  endtask

  task automatic test_known_vector();
    write_key(REG_KEY_HIGH, 64'h0001020304050607);
    write_key(REG_KEY_LOW, 64'h08090a0b0c0d0e0f);
    send_block(OP_ENC, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DEC, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    send_block(OP_ENC, 64'h8000000000000000, 64'h0000000000000001);
    send_block(OP_DEC, 64'h8000000000000000, 64'h0000000000000001);
  endtask

  task automatic test_key_extremes();
    write_key(REG_KEY_HIGH, '1);
    write_key(REG_KEY_LOW, '1);
    send_block(OP_ENC, '0, '1);
    send_block(OP_DEC, '1, '0);
    write_key(REG_KEY_LOW, '0);
    send_block(OP_ENC, 64'h0123456789abcdef, 64'hfedcba9876543210);
    write_key(REG_KEY_HIGH, '0);
    send_block(OP_DEC, 64'h0123456789abcdef, 64'hfedcba9876543210);
  endtask

  task automatic test_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 250 == 0) begin
        write_key(REG_KEY_HIGH, {$urandom, $urandom});
        write_key(REG_KEY_LOW, {$urandom, $urandom});
      end
      idle_pct = (i >= 500 && i < 700) ? 0 : 38;
      send_block(op_e'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom});
    end
  endtask

  initial begin
    fail_cnt = 0;
    idle_pct = 38;
    key_hi_q = '0;
    key_lo_q = '0;
    sched_ok = 1'b0;
    build_sboxes();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_zero_key();
    test_known_vector();
    test_key_extremes();
    test_random(1500);
    drain();
    if (fail_cnt == 0) $display("tb_aes128_block_cipher passed");
    else $display("tb_aes128_block_cipher failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb_aes128_block_cipher failed");
    $finish;
  end
endmodule

// File: sim.f
design/aes_pkg.sv
design/aes128_block_cipher.sv
dv/tb_aes128_block_cipher.sv
